// ===== design/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the skinning block
// Item format between the front decoder, the queue and the skinning engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 64;
  localparam int WORDS_PER_BONE      = 12;
  localparam int MATRIX_ROWS         = 4;
  localparam int QUEUE_DEPTH         = 2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SKIN,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_ROWS,
    E_WEIGH,
    E_ACC,
    E_EMIT
  } eng_state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [5:0]         bone;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [15:0]        vidx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [16:0]        weight;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Matrix word index to row and column of the palette column memories.
  function automatic logic [3:0] elem_decode(input logic [3:0] element);
    logic [3:0] rc;
    unique case (element)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      4'd9:    rc = {2'd3, 2'd0};
      4'd10:   rc = {2'd3, 2'd1};
      4'd11:   rc = {2'd3, 2'd2};
      default: rc = 4'd0;
    endcase
    return rc;
  endfunction

endpackage

`default_nettype wire

// ===== design/lbs_front.sv =====
// ----------------------------------------------------------------------------
// lbs_front: input acceptance and item classification
// Turns each input beat into a queue entry with a command code.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_front #(
  parameter int PALETTE_ENTRIES = lbs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_func,
  input  wire logic [5:0]          in_bone,
  input  wire logic [3:0]          in_element,
  input  wire logic [15:0]         in_vertex_index,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  input  wire logic signed [15:0]  in_norm_x,
  input  wire logic signed [15:0]  in_norm_y,
  input  wire logic signed [15:0]  in_norm_z,
  input  wire logic [16:0]         in_weight,
  input  wire logic                in_last,
  input  wire lbs_pkg::q_stat_t    q_stat,
  output logic                     push,
  output lbs_pkg::item_t           item
);

  localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);

  logic       bone_ok;
  logic       elem_ok;
  logic [3:0] rc;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign bone_ok = {3'b000, in_bone} < ENTRIES;
  assign elem_ok = in_element < 4'(lbs_pkg::WORDS_PER_BONE);
  assign rc      = lbs_pkg::elem_decode(in_element);

  always_comb begin
    item.bone   = in_bone;
    item.row    = rc[3:2];
    item.col    = rc[1:0];
    item.vidx   = in_vertex_index;
    item.px     = in_pos_x;
    item.py     = in_pos_y;
    item.pz     = in_pos_z;
    item.nx     = in_norm_x;
    item.ny     = in_norm_y;
    item.nz     = in_norm_z;
    item.weight = in_weight;
    item.last   = in_last;
    // An influence on a bone outside the palette adds nothing but still
    // closes the vertex when it carries the last mark.
    if (!in_func) begin
      item.cmd = (bone_ok && elem_ok) ? lbs_pkg::CMD_LOAD : lbs_pkg::CMD_NOP;
    end else if (bone_ok) begin
      item.cmd = lbs_pkg::CMD_SKIN;
    end else begin
      item.cmd = in_last ? lbs_pkg::CMD_EMIT : lbs_pkg::CMD_NOP;
    end
  end

endmodule

`default_nettype wire

// ===== design/lbs_queue.sv =====
// ----------------------------------------------------------------------------
// lbs_queue: short item queue between front and engine
// Register-based FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lbs_pkg::item_t   push_item,
  input  wire logic             pop,
  output lbs_pkg::item_t        head,
  output lbs_pkg::q_stat_t      q_stat
);

  localparam int DEPTH = lbs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbs_pkg::item_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head         = store_r[rd_ptr_r];
  assign q_stat.full  = count_r == CNT_W'(DEPTH);
  assign q_stat.empty = count_r == '0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/lbs_engine.sv =====
// ----------------------------------------------------------------------------
// lbs_engine: palette memory and skinning datapath
// Writes palette words, walks the four matrix rows of a bone, weights and
// accumulates the result, and emits the blended vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_engine #(
  parameter int PALETTE_ENTRIES = lbs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lbs_pkg::item_t   head,
  input  wire lbs_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_vidx,
  output logic [2:0][31:0]      out_pos,
  output logic [2:0][15:0]      out_norm,
  output logic                  out_sat
);

  localparam int MEM_DEPTH = PALETTE_ENTRIES * lbs_pkg::MATRIX_ROWS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic signed [64:0] PLIM = 65'sd4611686018427387904;
  localparam logic signed [48:0] NMAX = 49'sd140737488355327;
  localparam logic signed [48:0] NMIN = -49'sd140737488355328;
  localparam logic signed [63:0] P32MAX = 64'sd2147483647;
  localparam logic signed [63:0] P32MIN = -64'sd2147483648;
  localparam logic signed [47:0] N16MAX = 48'sd32767;
  localparam logic signed [47:0] N16MIN = -48'sd32768;

  lbs_pkg::eng_state_t st_r, st_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  lbs_pkg::item_t      item_r;
  logic                out_valid_r;
  logic [15:0]         out_vidx_r;

  logic take, mem_we, mul_en, sum_en, trans_en, weigh_en, acc_en, emit, out_free;
  logic [9:0]          waddr_full, raddr_full;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic signed [31:0]  psel;
  logic signed [15:0]  nsel;
  logic signed [17:0]  wgt_s;
  logic [2:0]          lane_sat;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      lbs_pkg::E_IDLE: begin
        if (!q_stat.empty) begin
          unique case (head.cmd)
            lbs_pkg::CMD_SKIN: begin
              st_nxt  = lbs_pkg::E_ROWS;
              cnt_nxt = 3'd0;
            end
            lbs_pkg::CMD_EMIT: st_nxt = lbs_pkg::E_EMIT;
            default: ;
          endcase
        end
      end
      lbs_pkg::E_ROWS: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          st_nxt = lbs_pkg::E_WEIGH;
        end
      end
      lbs_pkg::E_WEIGH: st_nxt = lbs_pkg::E_ACC;
      lbs_pkg::E_ACC:   st_nxt = item_r.last ? lbs_pkg::E_EMIT : lbs_pkg::E_IDLE;
      lbs_pkg::E_EMIT: begin
        if (out_free) begin
          st_nxt = lbs_pkg::E_IDLE;
        end
      end
      default: st_nxt = lbs_pkg::E_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = (st_r == lbs_pkg::E_IDLE) && !q_stat.empty;
    take     = 1'b0;
    mem_we   = 1'b0;
    if (pop) begin
      unique case (head.cmd)
        lbs_pkg::CMD_LOAD: mem_we = 1'b1;
        lbs_pkg::CMD_SKIN, lbs_pkg::CMD_EMIT: take = 1'b1;
        default: ;
      endcase
    end
    // Row r is read at step r, multiplied at step r+1 and summed at step r+2;
    // the translation row is added directly at step 4.
    mul_en   = (st_r == lbs_pkg::E_ROWS) && (cnt_r >= 3'd1) && (cnt_r <= 3'd3);
    sum_en   = (st_r == lbs_pkg::E_ROWS) && (cnt_r >= 3'd2);
    trans_en = (st_r == lbs_pkg::E_ROWS) && (cnt_r == 3'd4);
    weigh_en = st_r == lbs_pkg::E_WEIGH;
    acc_en   = st_r == lbs_pkg::E_ACC;
    emit     = (st_r == lbs_pkg::E_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lbs_pkg::E_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= head;
    end
    if (emit) begin
      out_vidx_r <= item_r.vidx;
    end
  end

  assign waddr_full = {2'b00, head.bone, head.row};
  assign raddr_full = {2'b00, item_r.bone, cnt_r[1:0]};
  assign waddr      = waddr_full[ADDR_W-1:0];
  assign raddr      = raddr_full[ADDR_W-1:0];
  assign wgt_s      = $signed({1'b0, item_r.weight});

  always_comb begin
    case (cnt_r)
      3'd2: begin
        psel = item_r.py;
        nsel = item_r.ny;
      end
      3'd3: begin
        psel = item_r.pz;
        nsel = item_r.nz;
      end
      default: begin
        psel = item_r.px;
        nsel = item_r.nx;
      end
    endcase
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_col
    logic [31:0]        mem [MEM_DEPTH];
    logic signed [31:0] mq_r;
    logic signed [63:0] prod_p_r;
    logic signed [47:0] prod_n_r;
    logic signed [49:0] tp_r;
    logic signed [33:0] tn_r;
    logic signed [67:0] wp_r;
    logic signed [51:0] wn_r;
    logic signed [63:0] pos_acc_r;
    logic signed [47:0] norm_acc_r;
    logic signed [31:0] out_p_r;
    logic signed [15:0] out_n_r;
    logic signed [63:0] pp;
    logic signed [47:0] np;
    logic signed [49:0] tp_add;
    logic signed [64:0] pos_sum;
    logic signed [48:0] norm_sum;
    logic signed [63:0] pos_cl;
    logic signed [47:0] norm_cl;
    logic               sat_p;
    logic               sat_n;

    always_ff @(posedge clk) begin
      if (mem_we && head.col == 2'(gc)) begin
        mem[waddr] <= head.px;
      end
      mq_r <= mem[raddr];
    end

    assign pp     = psel * mq_r;
    assign np     = nsel * mq_r;
    assign tp_add = 50'(prod_p_r >>> 16) + (trans_en ? 50'(mq_r) : 50'sd0);

    assign pos_sum  = 65'(pos_acc_r) + 65'(wp_r >>> 16);
    assign norm_sum = 49'(norm_acc_r) + 49'(wn_r >>> 16);

    always_comb begin
      if (pos_sum > PLIM) begin
        pos_cl = 64'(PLIM);
      end else if (pos_sum < -PLIM) begin
        pos_cl = 64'(-PLIM);
      end else begin
        pos_cl = 64'(pos_sum);
      end
      if (norm_sum > NMAX) begin
        norm_cl = 48'(NMAX);
      end else if (norm_sum < NMIN) begin
        norm_cl = 48'(NMIN);
      end else begin
        norm_cl = 48'(norm_sum);
      end
    end

    assign sat_p = (pos_acc_r > P32MAX) || (pos_acc_r < P32MIN);
    assign sat_n = (norm_acc_r > N16MAX) || (norm_acc_r < N16MIN);
    assign lane_sat[gc] = sat_p || sat_n;

    always_ff @(posedge clk) begin
      if (mul_en) begin
        prod_p_r <= pp;
        prod_n_r <= np;
      end
      if (take) begin
        tp_r <= '0;
        tn_r <= '0;
      end else if (sum_en) begin
        tp_r <= tp_r + tp_add;
        tn_r <= tn_r + 34'(prod_n_r >>> 16);
      end
      if (weigh_en) begin
        wp_r <= tp_r * wgt_s;
        wn_r <= tn_r * wgt_s;
      end
      if (emit) begin
        out_p_r <= sat_p ? (pos_acc_r[63] ? 32'sh80000000 : 32'sh7fffffff)
                         : 32'(pos_acc_r);
        out_n_r <= sat_n ? (norm_acc_r[47] ? 16'sh8000 : 16'sh7fff)
                         : 16'(norm_acc_r);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_acc_r  <= '0;
        norm_acc_r <= '0;
      end else if (emit) begin
        pos_acc_r  <= '0;
        norm_acc_r <= '0;
      end else if (acc_en) begin
        pos_acc_r  <= pos_cl;
        norm_acc_r <= norm_cl;
      end
    end

    assign out_pos[gc]  = out_p_r;
    assign out_norm[gc] = out_n_r;
  end

  logic out_sat_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sat_r <= |lane_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_vidx  = out_vidx_r;
  assign out_sat   = out_sat_r;

endmodule

`default_nettype wire

// ===== design/linear_blend_vertex_skinning.sv =====
// Flow: a palette load is queued, then written when the idle engine pops it;
// a last influence's result leaves from the emit state. Throughput: one
// palette load per cycle while the engine is idle; a new influence waits until
// the last is done. The engine reads the four matrix rows of a bone through
// one memory port per column, then weights and accumulates in two more steps.
// Reset: synchronous, active low; clears control and the accumulators only.
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: fixed-point linear blend skinning
// Palette of affine bone matrices and per-vertex weighted blend of position
// and normal, with saturated results.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_blend_vertex_skinning #(
  parameter int PALETTE_ENTRIES = lbs_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [5:0]         in_bone,
  input  wire logic [3:0]         in_element,
  input  wire logic [15:0]        in_vertex_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_norm_x,
  input  wire logic signed [15:0] in_norm_y,
  input  wire logic signed [15:0] in_norm_z,
  input  wire logic [16:0]        in_weight,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_vertex_index,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_norm_x,
  output logic signed [15:0]      out_norm_y,
  output logic signed [15:0]      out_norm_z,
  output logic                    out_saturated
);

  lbs_pkg::q_stat_t q_stat;
  lbs_pkg::item_t   push_item;
  lbs_pkg::item_t   head;
  logic             push;
  logic             pop;
  logic [2:0][31:0] out_pos;
  logic [2:0][15:0] out_norm;

  lbs_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_bone         (in_bone),
    .in_element      (in_element),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_norm_x       (in_norm_x),
    .in_norm_y       (in_norm_y),
    .in_norm_z       (in_norm_z),
    .in_weight       (in_weight),
    .in_last         (in_last),
    .q_stat          (q_stat),
    .push            (push),
    .item            (push_item)
  );

  lbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  lbs_engine #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_vidx  (out_vertex_index),
    .out_pos   (out_pos),
    .out_norm  (out_norm),
    .out_sat   (out_saturated)
  );

  assign out_pos_x  = out_pos[0];
  assign out_pos_y  = out_pos[1];
  assign out_pos_z  = out_pos[2];
  assign out_norm_x = out_norm[0];
  assign out_norm_y = out_norm[1];
  assign out_norm_z = out_norm[2];

endmodule

`default_nettype wire
